FILE: design/mrp_pkg.sv
// ============================================================================
// MIPS relocation patcher package
// Shared relocation type codes, status codes and configuration types.
// ============================================================================
package mrp_pkg;

    // Relocation types in the standard MIPS ELF numbering
    localparam logic [7:0] RT_32      = 8'd2;
    localparam logic [7:0] RT_26      = 8'd4;
    localparam logic [7:0] RT_HI16    = 8'd5;
    localparam logic [7:0] RT_LO16    = 8'd6;
    localparam logic [7:0] RT_GOT16   = 8'd9;
    localparam logic [7:0] RT_CALL16  = 8'd11;
    localparam logic [7:0] RT_GPREL32 = 8'd12;
    localparam logic [7:0] RT_JALR    = 8'd37;

    // Symbol kinds
    localparam logic [1:0] SYM_ORDINARY = 2'd0;
    localparam logic [1:0] SYM_LOCAL_GP = 2'd1;
    localparam logic [1:0] SYM_GP_DISP  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOT_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GP_ZERO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE = 2'd3;

    localparam int FILL_W = 16;
    localparam int GOT_OFS_W = 15;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_RANGE       = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_GOT_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] got_base;
        logic [31:0] gp_zero;
        logic [31:0] segment_base;
        logic [31:0] segment_size;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  mode;
        logic [31:0] symbol_value;
        logic [1:0]  symbol_kind;
        logic        symbol_is_local;
        logic [31:0] place_offset;
        logic [31:0] original_word;
        logic        partner_found;
        logic [15:0] partner_low;
    } reloc_t;

    typedef struct packed {
        logic [31:0]          patched_word;
        logic                 got_write;
        logic [31:0]          got_entry_value;
        logic [GOT_OFS_W-1:0] got_entry_offset;
        status_t              status;
    } result_t;

endpackage

FILE: design/mrp_apply.sv
// ============================================================================
// MIPS relocation patcher: relocation arithmetic
// Computes the patched word, the GOT entry and the status for one word.
// ============================================================================
module mrp_apply
    import mrp_pkg::*;
#(
    parameter int GOT_BYTES = 32768
)
(
    input  reloc_t            rel,
    input  cfg_t              cfg,
    input  logic [FILL_W-1:0] fill,
    output result_t           res,
    output logic              got_take
);

    logic [31:0] place_addr;
    logic [31:0] sym;
    logic [31:0] partner;
    logic [31:0] low;
    logic [31:0] hi_sum;
    logic [31:0] j_sum;
    logic [31:0] local_got;
    logic        got_full;

    always_comb
    begin
        place_addr = cfg.segment_base + rel.place_offset;
        partner    = rel.partner_found ? {{16{rel.partner_low[15]}}, rel.partner_low} : 32'd0;
        low        = {16'd0, rel.original_word[15:0]};

        unique case (rel.symbol_kind)
            SYM_LOCAL_GP: sym = cfg.got_base;
            SYM_GP_DISP:  sym = cfg.got_base - place_addr
                                + ((rel.mode == RT_LO16) ? 32'd4 : 32'd0);
            default:      sym = rel.symbol_value;
        endcase

        // HI16 and local GOT16 share the rounded high-half sum.
        hi_sum    = {rel.original_word[15:0], 16'd0} + sym + 32'h0000_8000 + partner;
        local_got = {hi_sum[31:16], 16'd0};
        j_sum     = {4'd0, rel.original_word[25:0], 2'b00} + sym;
        got_full  = ({1'b0, fill} + 17'd4) > 17'(GOT_BYTES);

        res.patched_word     = rel.original_word;
        res.got_write        = 1'b0;
        res.got_entry_value  = 32'd0;
        res.got_entry_offset = '0;
        res.status           = ST_OK;
        got_take             = 1'b0;

        if (rel.place_offset > cfg.segment_size)
        begin
            res.status = ST_RANGE;
        end
        else
        begin
            unique case (rel.mode)
                RT_HI16:
                    res.patched_word = {rel.original_word[31:16], hi_sum[31:16]};
                RT_LO16:
                    res.patched_word = {rel.original_word[31:16],
                                        rel.original_word[15:0] + sym[15:0]};
                RT_32:
                    res.patched_word = rel.original_word + sym;
                RT_GPREL32:
                    res.patched_word = sym + rel.original_word + cfg.gp_zero - cfg.got_base;
                RT_26:
                    res.patched_word = {rel.original_word[31:26], j_sum[27:2]};
                RT_GOT16, RT_CALL16:
                begin
                    if (got_full)
                    begin
                        res.status = ST_GOT_FULL;
                    end
                    else
                    begin
                        got_take             = 1'b1;
                        res.got_write        = 1'b1;
                        res.got_entry_offset = fill[GOT_OFS_W-1:0];
                        res.patched_word     = {rel.original_word[31:16], fill};
                        if (rel.mode == RT_GOT16 && rel.symbol_is_local)
                            res.got_entry_value = local_got;
                        else
                            res.got_entry_value = sym + low;
                    end
                end
                RT_JALR:
                    res.patched_word = rel.original_word;
                default:
                    res.status = ST_UNSUPPORTED;
            endcase
        end
    end

endmodule

FILE: design/mips_relocation_patcher.sv
// ============================================================================
// MIPS relocation patcher
// Applies one MIPS32 ELF relocation per input word and emits one result word.
// ============================================================================
// The block takes one relocation word per clock while the output is not
// stalled and returns one result word for each relocation that it accepts.
// An input register holds the accepted word, a single level of relocation
// arithmetic (a few 32-bit adds, a compare and selection) follows it, and a
// result register drives the output, so the sustained rate is one word per
// cycle without output stalls. The running GOT fill offset is updated in
// the same cycle that a GOT16 or CALL16 word moves into the result
// register, so back-to-back GOT relocations see each other's offsets. The
// configuration registers are written through their own channel, which is
// always ready; they must only be changed while no relocation is in flight.
module mips_relocation_patcher
    import mrp_pkg::*;
#(
    parameter int GOT_BYTES = 32768
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           mode,
    input  logic [31:0]          symbol_value,
    input  logic [1:0]           symbol_kind,
    input  logic                 symbol_is_local,
    input  logic [31:0]          place_offset,
    input  logic [31:0]          original_word,
    input  logic                 partner_found,
    input  logic signed [15:0]   partner_low,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          patched_word,
    output logic                 got_write,
    output logic [31:0]          got_entry_value,
    output logic [GOT_OFS_W-1:0] got_entry_offset,
    output logic [1:0]           status,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t              cfg_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              s1_valid_reg;
    reloc_t            s1_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           res;
    logic              got_take;
    logic              out_load;
    logic              s1_load;

    // Configuration channel: always ready, one register per write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GOT_BASE:     cfg_reg.got_base     <= cfg_data;
                CFG_GP_ZERO:      cfg_reg.gp_zero      <= cfg_data;
                CFG_SEGMENT_BASE: cfg_reg.segment_base <= cfg_data;
                CFG_SEGMENT_SIZE: cfg_reg.segment_size <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The result register loads whenever the input register holds a word and it
    // is empty or being drained, and the input register loads whenever its content moves on or it is empty.
    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load  = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (out_load)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg.mode            <= mode;
            s1_reg.symbol_value    <= symbol_value;
            s1_reg.symbol_kind     <= symbol_kind;
            s1_reg.symbol_is_local <= symbol_is_local;
            s1_reg.place_offset    <= place_offset;
            s1_reg.original_word   <= original_word;
            s1_reg.partner_found   <= partner_found;
            s1_reg.partner_low     <= partner_low;
        end
    end

    mrp_apply #(
        .GOT_BYTES (GOT_BYTES)
    ) u_apply (
        .rel      (s1_reg),
        .cfg      (cfg_reg),
        .fill     (fill_reg),
        .res      (res),
        .got_take (got_take)
    );

    // The fill offset advances by one GOT entry for every GOT write issued.
    assign fill_next = (out_load && got_take) ? fill_reg + FILL_W'(4) : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res;
    end

    assign out_valid        = out_valid_reg;
    assign patched_word     = out_reg.patched_word;
    assign got_write        = out_reg.got_write;
    assign got_entry_value  = out_reg.got_entry_value;
    assign got_entry_offset = out_reg.got_entry_offset;
    assign status           = out_reg.status;

    // The fill offset never passes the GOT limit.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, fill_reg} <= 17'(GOT_BYTES))
        else $error("GOT fill offset beyond GOT limit");

    // The fill offset only ever steps by one entry.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != $past(fill_reg) |-> fill_reg == $past(fill_reg) + FILL_W'(4))
        else $error("GOT fill offset changed by other than one entry");

    // A GOT write is only issued together with an ok status.
    a_got_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && got_write |-> status == ST_OK)
        else $error("GOT write issued with an error status");

    // A GOT write that enters the result register advances the fill offset.
    a_fill_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && got_take |=> fill_reg[GOT_OFS_W-1:0]
                                 == out_reg.got_entry_offset + GOT_OFS_W'(4))
        else $error("GOT fill offset did not follow the issued entry");

endmodule
